// ----- hdl/mfmt_pkg.sv -----
// Shared types and constants for the motor feedback multiturn tracker.
// No dependencies; every other file of the block imports this package.
package mfmt_pkg;

    localparam int NUM_MOTORS   = 8;
    localparam int ID_W         = 3;
    localparam int ENC_W        = 16;
    localparam int OFFSET_W     = 13;
    localparam int ACC_W        = 32;
    // One full turn is 8192 counts, so a turn count is shifted by 13.
    localparam int TURN_SHIFT   = 13;
    localparam int JUMP_LIMIT   = 4096;
    localparam int PAYLOAD_W    = 64;
    localparam int S_TUSER_W    = 3;
    localparam int M_TDATA_W    = 152;
    localparam int M_TUSER_W    = 3;

    // Configuration write as seen by the tracker core.
    typedef struct packed {
        logic                wen;
        logic [ID_W-1:0]     idx;
        logic [OFFSET_W-1:0] wdata;
    } t_cfg_wr;

    // One accepted input word.
    typedef struct packed {
        logic                 motor_group;
        logic [1:0]           motor_slot;
        logic [PAYLOAD_W-1:0] frame_payload;
    } t_in_word;

    // One result word.
    typedef struct packed {
        logic [ID_W-1:0]         motor_id;
        logic [ENC_W-1:0]        encoder_position;
        logic signed [15:0]      shaft_speed;
        logic signed [15:0]      phase_current;
        logic [7:0]              temperature;
        logic signed [ACC_W-1:0] turn_count;
        logic signed [ACC_W-1:0] multiturn_angle;
        logic signed [ACC_W-1:0] angle_error;
    } t_result;

endpackage

// ----- hdl/mfmt_in_stage.sv -----
// Input register of the tracker: holds one accepted word until it advances.
// Depends on mfmt_pkg.
module mfmt_in_stage import mfmt_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_word i_word,
    input  logic     i_adv,
    output logic     o_valid,
    output t_in_word o_word
);

    logic     r_valid;
    t_in_word r_word;

    // Take a new word when empty or when the held one moves on.
    assign o_ready = !r_valid || i_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Load payload on accept.
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_word <= i_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// ----- hdl/mfmt_track.sv -----
// Tracker core: offset registers, per-motor state and the turn/angle update.
// Depends on mfmt_pkg.
module mfmt_track import mfmt_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cfg_wr                 i_cfg,
    input  logic                    i_adv,
    input  logic [ID_W-1:0]         i_id,
    input  logic [ENC_W-1:0]        i_enc,
    output logic signed [ACC_W-1:0] o_turn,
    output logic signed [ACC_W-1:0] o_total,
    output logic signed [ACC_W-1:0] o_err
);

    logic [NUM_MOTORS-1:0][OFFSET_W-1:0] r_offset;
    logic [NUM_MOTORS-1:0][ENC_W-1:0]    r_prev_enc;
    logic [NUM_MOTORS-1:0][ACC_W-1:0]    r_turn;
    logic [NUM_MOTORS-1:0][ACC_W-1:0]    r_prev_total;

    logic signed [ENC_W:0] diff;
    logic [ACC_W-1:0]      n_turn;
    logic [ACC_W-1:0]      n_total;
    logic [ACC_W-1:0]      n_err;

    // Encoder jump decides the turn step.
    always_comb begin
        diff = $signed({1'b0, i_enc}) - $signed({1'b0, r_prev_enc[i_id]});
        n_turn = r_turn[i_id];
        if (diff > (ENC_W+1)'(JUMP_LIMIT)) begin
            n_turn = r_turn[i_id] - ACC_W'(1);
        end else if (diff < -(ENC_W+1)'(JUMP_LIMIT)) begin
            n_turn = r_turn[i_id] + ACC_W'(1);
        end
        n_total = (n_turn << TURN_SHIFT) + ACC_W'(i_enc) - ACC_W'(r_offset[i_id]);
        n_err   = r_prev_total[i_id] - n_total;
    end

    assign o_turn  = $signed(n_turn);
    assign o_total = $signed(n_total);
    assign o_err   = $signed(n_err);

    // Offset registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
        end else if (i_cfg.wen) begin
            r_offset[i_cfg.idx] <= i_cfg.wdata;
        end
    end

    // Write back the state of the motor that advances.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_enc   <= '0;
            r_turn       <= '0;
            r_prev_total <= '0;
        end else if (i_adv) begin
            r_prev_enc[i_id]   <= i_enc;
            r_turn[i_id]       <= n_turn;
            r_prev_total[i_id] <= n_total;
        end
    end

`ifndef SYNTHESIS
    // State moves only when a word advances.
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_adv |=> $stable(r_turn) && $stable(r_prev_enc) && $stable(r_prev_total))
        else $error("tracker state changed without an advancing word");

    // The turn counter steps by at most one per word.
    a_turn_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv |=> (r_turn[$past(i_id)] == $past(r_turn[i_id]))
               || (r_turn[$past(i_id)] == $past(r_turn[i_id]) + ACC_W'(1))
               || (r_turn[$past(i_id)] == $past(r_turn[i_id]) - ACC_W'(1)))
        else $error("turn counter jumped by more than one");

    // The stored encoder is the one just processed.
    a_enc_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv |=> r_prev_enc[$past(i_id)] == $past(i_enc))
        else $error("previous encoder not updated");
`endif

endmodule

// ----- hdl/mfmt_out_stage.sv -----
// Result register of the tracker: holds one result word until taken.
// Depends on mfmt_pkg.
module mfmt_out_stage import mfmt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    input  logic    i_tready,
    output logic    o_ready,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    // Room when empty or when the held word is taken this cycle.
    assign o_ready = !r_valid || i_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    // Capture the new result.
    always_ff @(posedge i_clk) begin
        if (i_load && o_ready) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ----- hdl/motor_feedback_multiturn_tracker_unit.sv -----
// An accepted input word passes through the input register, then the result register, to the master side.
// Throughput: one word per cycle while the master side takes results; the per-motor state read and
// turn update are combinational between the input and result registers, written back as the result loads.
// Reset (i_rst_n low, synchronous): both stages empty, offsets, turn counters,
// previous encoder and previous total of all eight motors cleared to zero.
module motor_feedback_multiturn_tracker_unit import mfmt_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_wen,
    input  logic [ID_W-1:0]      i_cfg_idx,
    input  logic [OFFSET_W-1:0]  i_cfg_wdata,
    // slave side
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [PAYLOAD_W-1:0] i_s_tdata,   // [63:0] frame_payload
    input  logic [S_TUSER_W-1:0] i_s_tuser,   // [0] motor_group, [2:1] motor_slot
    // master side
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // [15:0] encoder_position, [31:16] shaft_speed, [47:32] phase_current,
    // [55:48] temperature, [87:56] turn_count, [119:88] multiturn_angle,
    // [151:120] angle_error
    output logic [M_TDATA_W-1:0] o_m_tdata,
    output logic [M_TUSER_W-1:0] o_m_tuser    // [2:0] motor_id
);

    t_cfg_wr         cfg;
    t_in_word        s_word;
    t_in_word        in_word;
    logic            in_valid;
    logic            out_ready;
    logic            adv;
    logic [ID_W-1:0] id;
    t_result         res;
    t_result         out_res;
    logic signed [ACC_W-1:0] turn;
    logic signed [ACC_W-1:0] total;
    logic signed [ACC_W-1:0] err;

    assign cfg = '{wen: i_cfg_wen, idx: i_cfg_idx, wdata: i_cfg_wdata};

    assign s_word = '{motor_group:   i_s_tuser[0],
                      motor_slot:    i_s_tuser[2:1],
                      frame_payload: i_s_tdata};

    // Advance the held word when the result register has room.
    assign adv = in_valid && out_ready;

    mfmt_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_word  (s_word),
        .i_adv   (adv),
        .o_valid (in_valid),
        .o_word  (in_word)
    );

    assign id = {in_word.motor_group, in_word.motor_slot};

    mfmt_track u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_adv   (adv),
        .i_id    (id),
        .i_enc   (in_word.frame_payload[63:48]),
        .o_turn  (turn),
        .o_total (total),
        .o_err   (err)
    );

    // Unpack the frame bytes, byte 0 most significant.
    always_comb begin
        res.motor_id         = id;
        res.encoder_position = in_word.frame_payload[63:48];
        res.shaft_speed      = $signed(in_word.frame_payload[47:32]);
        res.phase_current    = $signed(in_word.frame_payload[31:16]);
        res.temperature      = in_word.frame_payload[15:8];
        res.turn_count       = turn;
        res.multiturn_angle  = total;
        res.angle_error      = err;
    end

    mfmt_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (adv),
        .i_res    (res),
        .i_tready (i_m_tready),
        .o_ready  (out_ready),
        .o_valid  (o_m_tvalid),
        .o_res    (out_res)
    );

    // Pack the result word, first field lowest.
    assign o_m_tdata = {out_res.angle_error, out_res.multiturn_angle, out_res.turn_count,
                        out_res.temperature, out_res.phase_current, out_res.shaft_speed,
                        out_res.encoder_position};
    assign o_m_tuser = out_res.motor_id;

endmodule
